[rtl/core/ptw_pkg.sv]
// Shared types, constants and helpers for the four-level page table walker.
package ptw_pkg;

  localparam int VIRT_ADDR_BITS = 48;
  localparam int ADDR_W         = 52;
  localparam int ENTRY_W        = 64;
  localparam int LEVELS         = 4;
  localparam int IN_DATA_W      = 112;
  localparam int OUT_DATA_W     = 368;

  localparam int ENTRY_PRESENT_BIT = 0;
  localparam int ENTRY_HUGE_BIT    = 7;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  localparam logic [1:0] LVL_TOP    = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_THIRD  = 2'd2;
  localparam logic [1:0] LVL_LEAF   = 2'd3;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  typedef enum logic [1:0] {
    RK_READ  = 2'd0,
    RK_DONE  = 2'd1,
    RK_FAULT = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic                           busy;
    logic [1:0]                     level;
    logic [VIRT_ADDR_BITS-1:0]      va;
    logic [LEVELS-1:0][ENTRY_W-1:0] entries;
  } walk_state_t;

  typedef struct packed {
    result_kind_t                   kind;
    logic [ADDR_W-1:0]              read_address;
    logic [ADDR_W-1:0]              translated_address;
    logic [1:0]                     pg_size;
    logic [1:0]                     fault_level;
    logic [LEVELS-1:0][ENTRY_W-1:0] entries;
  } walk_result_t;

  // Nine-bit table index for a level: va bits 47..39, 38..30, 29..21, 20..12.
  function automatic logic [8:0] level_index(logic [VIRT_ADDR_BITS-1:0] va,
                                             logic [1:0] lvl);
    logic [8:0] idx;
    unique case (lvl)
      LVL_TOP:    idx = va[47:39];
      LVL_SECOND: idx = va[38:30];
      LVL_THIRD:  idx = va[29:21];
      default:    idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

[rtl/core/four_level_page_table_walker_top.sv]
// Four-level page table walker: input register, step logic, two-deep output queue.
// An item waits in the input register; the step logic's result enters the output queue.
// Throughput: one item per cycle while the output queue has room; the step is one pass.
// Items that cause no result (request while busy, response while idle) are dropped.
// Reset (rst, synchronous): walker idle, queues empty, root table address zero.
module four_level_page_table_walker_top #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ptw_pkg::ADDR_W-1:0]          cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [47:0] vaddr, [111:48] read_data
  input  logic [ptw_pkg::IN_DATA_W-1:0]       s_tdata,
  // [0] req_type
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [51:0] read_address, [103:52] translated_address, [105:104] pg_size,
  // [107:106] fault_level, [171:108] top_entry, [235:172] second_entry,
  // [299:236] third_entry, [363:300] leaf_entry, [367:364] zero
  output logic [ptw_pkg::OUT_DATA_W-1:0]      m_tdata,
  // [1:0] result_kind
  output logic [1:0]                          m_tuser
);
  import ptw_pkg::*;

  logic [ADDR_W-1:0]         root;
  logic                      in_valid;
  logic                      in_req;
  logic [VIRT_ADDR_BITS-1:0] in_va;
  logic [ENTRY_W-1:0]        in_data;
  walk_state_t               st;
  walk_state_t               st_next;
  logic                      emit;
  walk_result_t              res;
  walk_result_t              out_res;
  walk_result_t              sk_res;
  logic                      sk_valid;
  logic                      proceed;
  logic                      fire;
  logic                      push;
  logic                      pop;
  logic                      in_fire;

  assign proceed  = !(m_tvalid && sk_valid);
  assign fire     = in_valid && proceed;
  assign push     = fire && emit;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = !in_valid || proceed;
  assign in_fire  = s_tvalid && s_tready;

  ptw_step #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_step (
    .st              (st),
    .root            (root),
    .req_type        (in_req),
    .vaddr           (in_va),
    .read_data       (in_data),
    .st_next         (st_next),
    .emit            (emit),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_we) begin
      root <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (proceed) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_req  <= s_tuser;
      in_va   <= s_tdata[VIRT_ADDR_BITS-1:0];
      in_data <= s_tdata[IN_DATA_W-1:VIRT_ADDR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (sk_valid) begin
        m_tvalid <= 1'b1;
        sk_valid <= push;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      if (sk_valid) begin
        out_res <= sk_res;
        sk_res  <= res;
      end else begin
        out_res <= res;
      end
    end else if (push) begin
      sk_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {4'b0000, out_res.entries[3], out_res.entries[2],
                    out_res.entries[1], out_res.entries[0], out_res.fault_level,
                    out_res.pg_size, out_res.translated_address,
                    out_res.read_address};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> m_tvalid)
    else $error("skid entry valid while output register empty");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && in_req == REQ_TRANSLATE && !st.busy) |=> st.busy)
    else $error("translate request did not start a walk");

  a_read_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == RK_READ) |=> st.busy)
    else $error("read request issued without an active walk");

  a_end_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (push && (res.kind == RK_DONE || res.kind == RK_FAULT)) |=> !st.busy)
    else $error("walk still busy after done or fault");

endmodule

[rtl/core/ptw_step.sv]
// One walker step: next walk state and the result item for one input item.
module ptw_step #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  ptw_pkg::walk_state_t                 st,
  input  logic [ptw_pkg::ADDR_W-1:0]           root,
  input  logic                                 req_type,
  input  logic [ptw_pkg::VIRT_ADDR_BITS-1:0]   vaddr,
  input  logic [ptw_pkg::ENTRY_W-1:0]          read_data,
  output ptw_pkg::walk_state_t                 st_next,
  output logic                                 emit,
  output ptw_pkg::walk_result_t                res
);
  import ptw_pkg::*;

  localparam logic [ADDR_W-1:0] PMASK =
    ADDR_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

  logic [ADDR_W-1:0] root_base;
  logic [ADDR_W-1:0] data_phys;
  logic [1:0]        lvl;
  logic [1:0]        lvl_next;

  assign root_base = root & PMASK;
  assign data_phys = read_data[ADDR_W-1:0] & PMASK;
  assign lvl       = st.level;
  assign lvl_next  = lvl + 2'd1;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '0;
    if (req_type == REQ_TRANSLATE) begin
      if (!st.busy) begin
        st_next.busy    = 1'b1;
        st_next.level   = LVL_TOP;
        st_next.va      = vaddr;
        st_next.entries = '0;
        emit             = 1'b1;
        res.kind         = RK_READ;
        res.read_address = {root_base[ADDR_W-1:12],
                            level_index(vaddr, LVL_TOP), 3'b000} & PMASK;
      end
    end else if (st.busy) begin
      st_next.entries[lvl] = read_data;
      emit = 1'b1;
      if (!read_data[ENTRY_PRESENT_BIT]) begin
        st_next.busy    = 1'b0;
        res.kind        = RK_FAULT;
        res.fault_level = lvl;
      end else if (lvl == LVL_SECOND && read_data[ENTRY_HUGE_BIT]) begin
        st_next.busy           = 1'b0;
        res.kind               = RK_DONE;
        res.pg_size            = PS_1G;
        res.translated_address = {data_phys[ADDR_W-1:30], st.va[29:0]} & PMASK;
      end else if (lvl == LVL_THIRD && read_data[ENTRY_HUGE_BIT]) begin
        st_next.busy           = 1'b0;
        res.kind               = RK_DONE;
        res.pg_size            = PS_2M;
        res.translated_address = {data_phys[ADDR_W-1:21], st.va[20:0]} & PMASK;
      end else if (lvl == LVL_LEAF) begin
        st_next.busy           = 1'b0;
        res.kind               = RK_DONE;
        res.pg_size            = PS_4K;
        res.translated_address = {data_phys[ADDR_W-1:12], st.va[11:0]} & PMASK;
      end else begin
        st_next.level    = lvl_next;
        res.kind         = RK_READ;
        res.read_address = {data_phys[ADDR_W-1:12],
                            level_index(st.va, lvl_next), 3'b000} & PMASK;
      end
    end
    res.entries = st_next.entries;
  end

endmodule
